// File: src/fed_pkg.sv
// fed_pkg: shared constants for the feedback echo delay block
// register indexes, register widths and reset values; no dependencies
package fed_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 17;
  localparam int DELAY_W     = 16;
  localparam int GAIN_W      = 16;
  localparam int MIX_W       = 17;
  localparam int Q_SHIFT     = 16;
  localparam int ROUND_HALF  = 32768;

  localparam logic [CFG_INDEX_W-1:0] REG_DELAY_SAMPLES = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FEEDBACK_GAIN = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MIX_LEVEL     = 2'd2;

  localparam int              DELAY_RESET = 24000;
  localparam logic [GAIN_W-1:0] GAIN_RESET  = 16'd16384;
  localparam logic [MIX_W-1:0]  MIX_RESET   = 17'd32768;
  localparam logic [MIX_W-1:0]  MIX_FULL    = 17'd65536;

endpackage

// File: src/fed_ram.sv
// fed_ram: generic single-port-write, single-port-read RAM with registered read
// no package dependencies; contents are undefined until written
module fed_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024,
  localparam int AddrW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AddrW-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

// File: src/feedback_echo_delay.sv
// feedback_echo_delay: per-channel feedback echo with dry/wet mix
// uses fed_pkg and one fed_ram instance holding all channel rings
// pipeline: an accepted sample passes stage 1, stage 2 and the sample_out register;
//   the whole pipeline holds while out_valid is high and out_ready is low
// throughput: one sample per cycle while the output is not stalled; in_ready drops
//   while a sample would read the ring entry that the sample in stage 1 writes (same channel, delay of one)
// reset and delay writes clear the rings at once through per-channel fill counters;
//   entries not yet written since then read as zero, no clearing pass
module feedback_echo_delay #(
  parameter int MAX_DELAY     = 65536,
  parameter int CHANNEL_COUNT = 2,
  parameter int SAMPLE_BITS   = 24
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [fed_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [fed_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              channel_index,
  input  logic signed [SAMPLE_BITS-1:0]     sample_in,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [SAMPLE_BITS-1:0]     sample_out
);

  import fed_pkg::*;

  localparam int AW      = $clog2(MAX_DELAY);
  localparam int DW      = $clog2(MAX_DELAY + 1);
  localparam int CW      = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam int RAM_D   = CHANNEL_COUNT * (2 ** AW);
  localparam int RAM_AW  = $clog2(RAM_D);
  localparam int PFB_W   = SAMPLE_BITS + GAIN_W + 1;
  localparam int PMIX_W  = SAMPLE_BITS + MIX_W + 1;
  localparam int WIDE_W  = SAMPLE_BITS + 3;
  localparam int DELAY_R = (DELAY_RESET > MAX_DELAY) ? MAX_DELAY : DELAY_RESET;

  function automatic logic [SAMPLE_BITS-1:0] sat_sample(input logic signed [WIDE_W-1:0] v);
    if (v[WIDE_W-1:SAMPLE_BITS-1] == {4{v[WIDE_W-1]}}) begin
      return v[SAMPLE_BITS-1:0];
    end else if (v[WIDE_W-1]) begin
      return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  endfunction

  // configuration
  logic [DW-1:0]     delay_eff;
  logic [GAIN_W-1:0] feedback;
  logic [MIX_W-1:0]  mix;
  logic [DW-1:0]     delay_wr;
  logic [MIX_W-1:0]  mix_wr;
  logic              clear_rings;

  // ring control
  logic [AW-1:0] wr_pos   [CHANNEL_COUNT];
  logic [DW-1:0] fill_cnt [CHANNEL_COUNT];

  // input side
  logic           adv;
  logic           accept;
  logic           hazard;
  logic [CW-1:0]  in_ch;
  logic [AW-1:0]  cur_wp;
  logic [DW-1:0]  cur_fill;
  logic [DW-1:0]  wp_ext;
  logic [AW-1:0]  rd_pos;
  logic [CW+AW-1:0] in_raddr;
  logic [CW+AW-1:0] in_waddr;

  // stage 1: read data back
  logic                          s1_valid;
  logic [CW+AW-1:0]              s1_raddr;
  logic [CW+AW-1:0]              s1_waddr;
  logic                          s1_rd_ok;
  logic signed [SAMPLE_BITS-1:0] s1_x;
  logic signed [SAMPLE_BITS-1:0] rd_data;
  logic signed [SAMPLE_BITS-1:0] delayed;
  logic [MIX_W-1:0]              inv_mix;
  logic signed [PFB_W-1:0]       pfb;
  logic signed [PMIX_W-1:0]      pdry;
  logic signed [PMIX_W-1:0]      pwet;

  // stage 2: products, write back
  logic                          s2_valid;
  logic [CW+AW-1:0]              s2_waddr;
  logic signed [SAMPLE_BITS-1:0] s2_x;
  logic signed [PFB_W-1:0]       s2_pfb;
  logic signed [PMIX_W-1:0]      s2_pdry;
  logic signed [PMIX_W-1:0]      s2_pwet;
  logic signed [PFB_W-1:0]       fb_sum;
  logic signed [SAMPLE_BITS:0]   fb;
  logic signed [SAMPLE_BITS+1:0] store_sum;
  logic signed [PMIX_W:0]        mix_sum;
  logic [SAMPLE_BITS-1:0]        wr_data;
  logic [SAMPLE_BITS-1:0]        y_sat;

  // last write, for a read issued on the same edge
  logic                   lw_valid;
  logic [CW+AW-1:0]       lw_addr;
  logic [SAMPLE_BITS-1:0] lw_data;

  // config decode
  always_comb begin
    if (cfg_data[DELAY_W-1:0] == '0) begin
      delay_wr = DW'(1);
    end else if (int'(cfg_data[DELAY_W-1:0]) > MAX_DELAY) begin
      delay_wr = DW'(MAX_DELAY);
    end else begin
      delay_wr = DW'(cfg_data[DELAY_W-1:0]);
    end
    mix_wr      = (cfg_data[MIX_W-1:0] > MIX_FULL) ? MIX_FULL : cfg_data[MIX_W-1:0];
    clear_rings = cfg_write && (cfg_index == REG_DELAY_SAMPLES);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_eff <= DW'(DELAY_R);
      feedback  <= GAIN_RESET;
      mix       <= MIX_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_DELAY_SAMPLES: delay_eff <= delay_wr;
        REG_FEEDBACK_GAIN: feedback  <= cfg_data[GAIN_W-1:0];
        REG_MIX_LEVEL:     mix       <= mix_wr;
        default: ;
      endcase
    end
  end

  // input side: read position and hazard against the sample one stage ahead
  always_comb begin
    in_ch    = (CHANNEL_COUNT > 1) ? CW'(channel_index) : '0;
    cur_wp   = wr_pos[in_ch];
    cur_fill = fill_cnt[in_ch];
    wp_ext   = DW'(cur_wp);
    if (wp_ext >= delay_eff) begin
      rd_pos = AW'(wp_ext - delay_eff);
    end else begin
      rd_pos = AW'(wp_ext + DW'(MAX_DELAY) - delay_eff);
    end
    in_raddr = {in_ch, rd_pos};
    in_waddr = {in_ch, cur_wp};
    adv      = !out_valid || out_ready;
    hazard   = s1_valid && (s1_waddr == in_raddr);
    in_ready = adv && !hazard;
    accept   = in_valid && in_ready;
  end

  always_ff @(posedge clk) begin
    if (rst || clear_rings) begin
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        wr_pos[i]   <= '0;
        fill_cnt[i] <= '0;
      end
    end else if (accept) begin
      wr_pos[in_ch] <= (cur_wp == AW'(MAX_DELAY - 1)) ? '0 : cur_wp + AW'(1);
      if (cur_fill != DW'(MAX_DELAY)) begin
        fill_cnt[in_ch] <= cur_fill + DW'(1);
      end
    end
  end

  fed_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (RAM_D)
  ) u_ring (
    .clk   (clk),
    .we    (s2_valid && adv),
    .waddr (RAM_AW'(s2_waddr)),
    .wdata (wr_data),
    .re    (accept),
    .raddr (RAM_AW'(in_raddr)),
    .rdata (rd_data)
  );

  // stage 1: pick delayed sample and multiply
  always_comb begin
    if (lw_valid && (lw_addr == s1_raddr)) begin
      delayed = lw_data;
    end else if (s1_rd_ok) begin
      delayed = rd_data;
    end else begin
      delayed = '0;
    end
    inv_mix = MIX_FULL - mix;
    pfb     = $signed({1'b0, feedback}) * delayed;
    pdry    = s1_x * $signed({1'b0, inv_mix});
    pwet    = delayed * $signed({1'b0, mix});
  end

  // stage 2: round, saturate
  always_comb begin
    fb_sum    = s2_pfb + PFB_W'(ROUND_HALF);
    fb        = fb_sum[PFB_W-1:Q_SHIFT];
    store_sum = (SAMPLE_BITS + 2)'(s2_x) + (SAMPLE_BITS + 2)'(fb);
    wr_data   = sat_sample(WIDE_W'(store_sum));
    mix_sum   = (PMIX_W + 1)'(s2_pdry) + (PMIX_W + 1)'(s2_pwet) + (PMIX_W + 1)'(ROUND_HALF);
    y_sat     = sat_sample(mix_sum[PMIX_W:Q_SHIFT]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= accept;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear_rings) begin
      lw_valid <= 1'b0;
    end else if (adv && s2_valid) begin
      lw_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_raddr   <= in_raddr;
      s1_waddr   <= in_waddr;
      s1_rd_ok   <= DW'(rd_pos) < cur_fill;
      s1_x       <= sample_in;
      s2_waddr   <= s1_waddr;
      s2_x       <= s1_x;
      s2_pfb     <= pfb;
      s2_pdry    <= pdry;
      s2_pwet    <= pwet;
      sample_out <= y_sat;
      if (s2_valid) begin
        lw_addr <= s2_waddr;
        lw_data <= wr_data;
      end
    end
  end

endmodule

// File: tb/feedback_echo_delay_tb.sv
// feedback_echo_delay_tb: self-checking bench for the per-channel feedback echo
// a scoreboard class predicts every sample_out from its own copy of the rings and registers;
// depends on fed_pkg and the feedback_echo_delay top level
module feedback_echo_delay_tb;
  import fed_pkg::*;

  localparam int RING_DEPTH = 65536;
  localparam int CLK_HALF = 4;
  localparam int RESET_CYCLES = 7;
  localparam int SETTLE_CYCLES = 8;
  localparam int LIMIT_CYCLES = 400000;
  localparam int BLOCK_ITEMS = 100;
  localparam int MAX_GAP = 40;
  localparam longint SAMPLE_HI = 64'sd8388607;
  localparam longint SAMPLE_LO = -64'sd8388608;
  localparam logic signed [23:0] SAMPLE_MAX = 24'sh7fffff;
  localparam logic signed [23:0] SAMPLE_MIN = 24'sh800000;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [CFG_DATA_W-1:0] MIX_ABOVE_FULL = 17'h1ffff;

  class echo_scoreboard;
    logic signed [23:0] ring_mem [int];
    int unsigned wr_pos [2];
    int unsigned delay_len;
    int unsigned gain;
    int unsigned mix;
    logic signed [23:0] due_samples [$];
    int errors;
    int noted;
    int checked;

    function new();
      ring_mem.delete();
      wr_pos = '{0, 0};
      delay_len = DELAY_RESET;
      gain = GAIN_RESET;
      mix = MIX_RESET;
      errors = 0;
      noted = 0;
      checked = 0;
    endfunction

    function longint clamp(longint v);
      if (v > SAMPLE_HI) return SAMPLE_HI;
      if (v < SAMPLE_LO) return SAMPLE_LO;
      return v;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_DELAY_SAMPLES: begin
          delay_len = data[DELAY_W-1:0];
          ring_mem.delete();
          wr_pos = '{0, 0};
        end
        REG_FEEDBACK_GAIN: gain = data[GAIN_W-1:0];
        REG_MIX_LEVEL: mix = data;
        default: ;
      endcase
    endfunction

    function void note_sample(bit ch, logic signed [23:0] x);
      int unsigned d;
      int unsigned m;
      int unsigned wp;
      int unsigned rp;
      int key;
      longint xin;
      longint delayed;
      longint fb;
      longint y;
      d = delay_len;
      if (d < 1) d = 1;
      if (d > RING_DEPTH) d = RING_DEPTH;
      m = (mix > MIX_FULL) ? MIX_FULL : mix;
      wp = wr_pos[ch];
      rp = (wp + RING_DEPTH - d) % RING_DEPTH;
      key = ch * RING_DEPTH + rp;
      delayed = ring_mem.exists(key) ? longint'(ring_mem[key]) : 0;
      xin = longint'(x);
      fb = (longint'(gain) * delayed + ROUND_HALF) >>> Q_SHIFT;
      ring_mem[ch * RING_DEPTH + wp] = 24'(clamp(xin + fb));
      wr_pos[ch] = (wp + 1) % RING_DEPTH;
      y = (xin * longint'(MIX_FULL - m) + delayed * longint'(m) + ROUND_HALF) >>> Q_SHIFT;
      due_samples.insert(due_samples.size(), 24'(clamp(y)));
      noted++;
    endfunction

    function void check_sample(logic signed [23:0] act);
      logic signed [23:0] want;
      if (due_samples.size() == 0) begin
        errors++;
        $display("%0t: sample_out %0d with no sample expected", $time, act);
        return;
      end
      want = due_samples.pop_front();
      checked++;
      if (act !== want) begin
        errors++;
        $display("%0t: sample_out mismatch, expected %0d, actual %0d", $time, want, act);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic channel_index = 1'b0;
  logic signed [23:0] sample_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [23:0] sample_out;

  echo_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;
  int cycle_count = 0;
  int write_count = 0;

  feedback_echo_delay dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .channel_index(channel_index),
    .sample_in(sample_in),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sample_out(sample_out)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver: long hold-off first, otherwise random stalls
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_sample(sample_out);
  end

  task automatic send_sample(bit ch, logic signed [23:0] x);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    channel_index <= ch;
    sample_in <= x;
    do @(posedge clk); while (!in_ready);
    sb.note_sample(ch, x);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.due_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    sb.write_reg(idx, data);
    write_count++;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic logic signed [23:0] rand_sample();
    case ($urandom_range(9))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2, 3: return 24'($signed($urandom_range(511)) - 256);
      default: return 24'($urandom());
    endcase
  endfunction

  task automatic random_settings();
    int pick;
    if ($urandom_range(2) != 0) begin
      pick = $urandom_range(9);
      if (pick < 6) write_reg(REG_DELAY_SAMPLES, 17'($urandom_range(8, 1)));
      else if (pick < 9) write_reg(REG_DELAY_SAMPLES, 17'($urandom_range(300, 9)));
      else write_reg(REG_DELAY_SAMPLES, $urandom_range(1) ? 17'd0 : 17'd65535);
    end
    if ($urandom_range(1)) begin
      pick = $urandom_range(3);
      if (pick == 0) write_reg(REG_FEEDBACK_GAIN, 17'd0);
      else if (pick == 1) write_reg(REG_FEEDBACK_GAIN, 17'd65535);
      else write_reg(REG_FEEDBACK_GAIN, 17'($urandom_range(65535)));
    end
    if ($urandom_range(1)) begin
      pick = $urandom_range(4);
      if (pick == 0) write_reg(REG_MIX_LEVEL, 17'd0);
      else if (pick == 1) write_reg(REG_MIX_LEVEL, MIX_FULL);
      else if (pick == 2) write_reg(REG_MIX_LEVEL, 17'($urandom_range(131071)));
      else write_reg(REG_MIX_LEVEL, 17'($urandom_range(65536)));
    end
    if ($urandom_range(7) == 0) write_reg(REG_UNUSED, 17'($urandom_range(131071)));
  endtask

  task automatic run_block(int count, int hold);
    random_settings();
    hold_left = hold;
    repeat (count) send_sample(1'($urandom_range(1)), rand_sample());
    drain();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: long delay, half wet
    send_sample(1'b0, SAMPLE_MAX);
    send_sample(1'b1, SAMPLE_MIN);
    send_sample(1'b0, 24'sd0);
    send_sample(1'b1, -24'sd1);
    send_sample(1'b0, 24'sd1);
    drain();

    // zero delay acts as one, full gain drives the store into saturation
    write_reg(REG_DELAY_SAMPLES, 17'd0);
    write_reg(REG_FEEDBACK_GAIN, 17'd65535);
    write_reg(REG_MIX_LEVEL, MIX_FULL);
    repeat (3) send_sample(1'b0, SAMPLE_MAX);
    repeat (3) send_sample(1'b1, SAMPLE_MIN);
    send_sample(1'b0, SAMPLE_MIN);
    send_sample(1'b1, SAMPLE_MAX);
    drain();

    // mix above full, write to an unused index, no feedback
    write_reg(REG_MIX_LEVEL, MIX_ABOVE_FULL);
    write_reg(REG_UNUSED, 17'd1);
    write_reg(REG_FEEDBACK_GAIN, 17'd0);
    send_sample(1'b0, 24'sd12345);
    send_sample(1'b0, -24'sd54321);
    send_sample(1'b1, 24'sd777);
    drain();

    // fully dry, longest delay
    write_reg(REG_MIX_LEVEL, 17'd0);
    write_reg(REG_DELAY_SAMPLES, 17'd65535);
    send_sample(1'b0, SAMPLE_MAX);
    send_sample(1'b1, SAMPLE_MIN);
    send_sample(1'b1, 24'sd4096);
    drain();

    send_idle_pct = 29;
    recv_idle_pct = 86;
    repeat (6) run_block(BLOCK_ITEMS, 0);

    send_idle_pct = 86;
    recv_idle_pct = 29;
    repeat (6) run_block(BLOCK_ITEMS, 0);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_block(BLOCK_ITEMS, 400);
    repeat (5) run_block(BLOCK_ITEMS, 0);

    $display("covered %0d sample transfers, %0d results checked, %0d register writes in %0d cycles",
             sb.noted, sb.checked, write_count, cycle_count);
    $display("delays from zero to 65535, gain and mix extremes, three stall mixes, one long output stall");
    if (sb.errors == 0 && sb.due_samples.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
